/* design/ctpf_pkg.sv */
// shared types, constants and control word layout for the cube tree peer finder
`default_nettype none

package ctpf_pkg;

  localparam int unsigned RANK_W  = 16;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned RADIX_W = 9;
  // a digit in base radix stays below 256
  localparam int unsigned DIG_W   = 8;
  // powers radix^0 .. radix^15 cover every rank
  localparam int unsigned NPW     = RANK_W;
  localparam int unsigned PIDX_W  = $clog2(NPW);
  localparam int unsigned BIT_W   = $clog2(DIG_W);
  localparam int unsigned STEP_W  = 4;

  localparam logic [SIZE_W-1:0]  MAX_GROUP   = 17'd65536;
  localparam logic [RADIX_W-1:0] MAX_RADIX   = 9'd256;
  localparam logic [RADIX_W-1:0] MIN_RADIX   = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd2;

  localparam logic [1:0] KIND_RECV    = 2'd0;
  localparam logic [1:0] KIND_SEND    = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  typedef logic [STEP_W-1:0] ctpf_step_t;

  // microprogram addresses
  localparam ctpf_step_t ST_IDLE     = 4'd0;
  localparam ctpf_step_t ST_INIT     = 4'd1;
  localparam ctpf_step_t ST_DIMS     = 4'd2;
  localparam ctpf_step_t ST_DIG_INIT = 4'd3;
  localparam ctpf_step_t ST_DIG_STEP = 4'd4;
  localparam ctpf_step_t ST_DIG_END  = 4'd5;
  localparam ctpf_step_t ST_PARENT   = 4'd6;
  localparam ctpf_step_t ST_SUCC     = 4'd7;
  localparam ctpf_step_t ST_CHILD    = 4'd8;
  localparam ctpf_step_t ST_FINISH   = 4'd9;
  localparam ctpf_step_t ST_INVALID  = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_DIMS,
    OP_DIG_INIT,
    OP_DIG_STEP,
    OP_DIG_END,
    OP_PARENT,
    OP_SUCC,
    OP_CHILD,
    OP_FINISH,
    OP_INVALID
  } ctpf_op_e;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_IN,
    CND_RANK_BAD,
    CND_PROD_LT,
    CND_J_NZ,
    CND_K_NZ,
    CND_TZ_Z
  } ctpf_cond_e;

  typedef struct packed {
    ctpf_op_e   op;
    ctpf_cond_e cond;
    ctpf_step_t target;
    logic       out_wait;
    logic       rd_tz;
  } ctpf_uop_t;

  typedef struct packed {
    ctpf_op_e op;
    logic     en;
    logic     rd_tz;
  } ctpf_ctrl_t;

  typedef struct packed {
    logic in_vld;
    logic rank_bad;
    logic prod_lt;
    logic j_nz;
    logic k_nz;
    logic tz_z;
    logic out_busy;
  } ctpf_stat_t;

endpackage

`default_nettype wire

/* design/ctpf_if.sv */
// request and response channel interfaces
`default_nettype none

interface ctpf_req_if
  import ctpf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              pattern_mode;
  logic [SIZE_W-1:0] group_size;
  logic [RANK_W-1:0] local_rank;

  modport source (output valid, output pattern_mode, output group_size,
                  output local_rank, input ready);
  modport sink   (input valid, input pattern_mode, input group_size,
                  input local_rank, output ready);
endinterface

interface ctpf_rsp_if
  import ctpf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        peer_kind;
  logic [RANK_W-1:0] peer_rank;
  logic              last;

  modport source (output valid, output peer_kind, output peer_rank,
                  output last, input ready);
  modport sink   (input valid, input peer_kind, input peer_rank,
                  input last, output ready);
endinterface

`default_nettype wire

/* design/ctpf_seq.sv */
// microprogram rom, step counter and jump logic
`default_nettype none

module ctpf_seq
  import ctpf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ctpf_stat_t stat_i,
  output ctpf_ctrl_t      ctrl_o
);

  function automatic ctpf_uop_t ucode(input ctpf_step_t addr);
    ctpf_uop_t w;
    unique case (addr)
      ST_IDLE:     w = '{OP_LOAD,     CND_NO_IN,    ST_IDLE,     1'b0, 1'b0};
      ST_INIT:     w = '{OP_INIT,     CND_RANK_BAD, ST_INVALID,  1'b0, 1'b0};
      ST_DIMS:     w = '{OP_DIMS,     CND_PROD_LT,  ST_DIMS,     1'b0, 1'b0};
      ST_DIG_INIT: w = '{OP_DIG_INIT, CND_NEVER,    ST_IDLE,     1'b0, 1'b0};
      ST_DIG_STEP: w = '{OP_DIG_STEP, CND_J_NZ,     ST_DIG_STEP, 1'b0, 1'b0};
      ST_DIG_END:  w = '{OP_DIG_END,  CND_K_NZ,     ST_DIG_STEP, 1'b0, 1'b0};
      ST_PARENT:   w = '{OP_PARENT,   CND_NEVER,    ST_IDLE,     1'b1, 1'b1};
      ST_SUCC:     w = '{OP_SUCC,     CND_TZ_Z,     ST_FINISH,   1'b1, 1'b1};
      ST_CHILD:    w = '{OP_CHILD,    CND_K_NZ,     ST_CHILD,    1'b1, 1'b0};
      ST_FINISH:   w = '{OP_FINISH,   CND_ALWAYS,   ST_IDLE,     1'b1, 1'b0};
      ST_INVALID:  w = '{OP_INVALID,  CND_ALWAYS,   ST_IDLE,     1'b1, 1'b0};
      default:     w = '{OP_NOP,      CND_ALWAYS,   ST_IDLE,     1'b0, 1'b0};
    endcase
    return w;
  endfunction

  ctpf_step_t step_q, step_d;
  ctpf_uop_t  uop;
  logic       stall;
  logic       jump;

  always_comb begin
    uop   = ucode(step_q);
    stall = uop.out_wait && stat_i.out_busy;
    unique case (uop.cond)
      CND_NEVER:    jump = 1'b0;
      CND_ALWAYS:   jump = 1'b1;
      CND_NO_IN:    jump = !stat_i.in_vld;
      CND_RANK_BAD: jump = stat_i.rank_bad;
      CND_PROD_LT:  jump = stat_i.prod_lt;
      CND_J_NZ:     jump = stat_i.j_nz;
      CND_K_NZ:     jump = stat_i.k_nz;
      CND_TZ_Z:     jump = stat_i.tz_z;
      default:      jump = 1'b1;
    endcase
    if (stall) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = uop.target;
    end else begin
      step_d = step_q + ctpf_step_t'(1);
    end
    ctrl_o.op    = uop.op;
    ctrl_o.en    = !stall;
    ctrl_o.rd_tz = uop.rd_tz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

/* design/ctpf_dp.sv */
// datapath: operand registers, power table, digit extraction and result staging
`default_nettype none

module ctpf_dp
  import ctpf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctpf_ctrl_t         ctrl_i,
  input  wire logic [RADIX_W-1:0] radix_i,
  output ctpf_stat_t              stat_o,
  ctpf_req_if.sink                req_i,
  ctpf_rsp_if.source              rsp_o
);

  localparam int unsigned PROD_W = RANK_W + RADIX_W;
  localparam int unsigned SH_W   = RANK_W + DIG_W - 1;

  function automatic logic [BIT_W-1:0] msb_idx(input logic [DIG_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < DIG_W; i++) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // item operands
  logic                mode_q;
  logic [SIZE_W-1:0]   size_q;
  logic [RANK_W-1:0]   rank_q;
  logic [RADIX_W-1:0]  radix_q;
  logic [BIT_W-1:0]    jtop_q;
  // powers of the radix and walk state
  logic [RANK_W-1:0]   pw_q [NPW];
  logic [PIDX_W-1:0]   k_q, tz_q;
  logic [BIT_W-1:0]    j_q;
  logic [RANK_W-1:0]   rem_q;
  logic [DIG_W-1:0]    dig_q, pos_q;
  // pending result and output register
  logic                pend_v_q, pend_v_d;
  logic [1:0]          pend_kind_q;
  logic [RANK_W-1:0]   pend_rank_q;
  logic                out_v_q, out_v_d;
  logic [1:0]          out_kind_q;
  logic [RANK_W-1:0]   out_rank_q;
  logic                out_last_q;

  logic                accept;
  logic [RADIX_W-1:0]  radix_eff, radix_eff_m1, radix_m1;
  logic [SIZE_W-1:0]   size_eff;
  logic [RANK_W-1:0]   pw_rd;
  logic [PROD_W-1:0]   prod;
  logic                prod_lt;
  logic [SH_W-1:0]     shifted;
  logic                ge;
  logic [SIZE_W-1:0]   sum;
  logic                sum_lt;
  logic                succ_ok;
  logic [1:0]          up_kind, down_kind;
  logic                cand_v;
  logic [1:0]          cand_kind;
  logic [RANK_W-1:0]   cand_rank;
  logic                pend_ld, out_ld;
  logic [1:0]          out_kind_n;
  logic [RANK_W-1:0]   out_rank_n;
  logic                out_last_n;

  assign req_i.ready = (ctrl_i.op == OP_LOAD);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid     = out_v_q;
  assign rsp_o.peer_kind = out_kind_q;
  assign rsp_o.peer_rank = out_rank_q;
  assign rsp_o.last      = out_last_q;

  always_comb begin
    radix_eff = (radix_i < MIN_RADIX) ? MIN_RADIX :
                (radix_i > MAX_RADIX) ? MAX_RADIX : radix_i;
    radix_eff_m1 = radix_eff - RADIX_W'(1);
    size_eff = (req_i.group_size > MAX_GROUP) ? MAX_GROUP : req_i.group_size;

    pw_rd   = pw_q[ctrl_i.rd_tz ? tz_q : k_q];
    prod    = {{RADIX_W{1'b0}}, pw_rd} * {{RANK_W{1'b0}}, radix_q};
    prod_lt = prod < {{(PROD_W-SIZE_W){1'b0}}, size_q};
    shifted = {{(DIG_W-1){1'b0}}, pw_rd} << j_q;
    ge      = {{(DIG_W-1){1'b0}}, rem_q} >= shifted;
    sum     = {1'b0, rank_q} + {1'b0, pw_rd};
    sum_lt  = sum < size_q;
    radix_m1 = radix_q - RADIX_W'(1);
    succ_ok = {1'b0, pos_q} < radix_m1;

    // reduce swaps the two roles
    up_kind   = mode_q ? KIND_SEND : KIND_RECV;
    down_kind = mode_q ? KIND_RECV : KIND_SEND;

    cand_v    = 1'b0;
    cand_kind = down_kind;
    cand_rank = sum[RANK_W-1:0];
    unique case (ctrl_i.op)
      OP_PARENT: begin
        cand_v    = (rank_q != '0);
        cand_kind = up_kind;
        cand_rank = rank_q - pw_rd;
      end
      OP_SUCC:  cand_v = succ_ok && sum_lt;
      OP_CHILD: cand_v = sum_lt;
      default:  cand_v = 1'b0;
    endcase
  end

  // result staging: one peer held back so the last mark can be set
  always_comb begin
    out_v_d    = out_v_q && !rsp_o.ready;
    pend_v_d   = pend_v_q;
    pend_ld    = 1'b0;
    out_ld     = 1'b0;
    out_kind_n = pend_kind_q;
    out_rank_n = pend_rank_q;
    out_last_n = 1'b0;
    if (ctrl_i.en) begin
      unique case (ctrl_i.op)
        OP_PARENT, OP_SUCC, OP_CHILD: begin
          if (cand_v) begin
            pend_ld  = 1'b1;
            pend_v_d = 1'b1;
            out_ld   = pend_v_q;
          end
        end
        OP_FINISH: begin
          out_ld     = 1'b1;
          out_last_n = 1'b1;
          pend_v_d   = 1'b0;
          if (!pend_v_q) begin
            out_kind_n = KIND_NONE;
            out_rank_n = '0;
          end
        end
        OP_INVALID: begin
          out_ld     = 1'b1;
          out_last_n = 1'b1;
          out_kind_n = KIND_INVALID;
          out_rank_n = '0;
        end
        default: ;
      endcase
    end
    if (out_ld) out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_ld) begin
      pend_kind_q <= cand_kind;
      pend_rank_q <= cand_rank;
    end
    if (out_ld) begin
      out_kind_q <= out_kind_n;
      out_rank_q <= out_rank_n;
      out_last_q <= out_last_n;
    end
    if (ctrl_i.en) begin
      unique case (ctrl_i.op)
        OP_LOAD: begin
          if (accept) begin
            mode_q  <= req_i.pattern_mode;
            size_q  <= size_eff;
            rank_q  <= req_i.local_rank;
            radix_q <= radix_eff;
            jtop_q  <= msb_idx(radix_eff_m1[DIG_W-1:0]);
          end
        end
        OP_INIT: begin
          pw_q[0] <= RANK_W'(1);
          k_q     <= '0;
        end
        OP_DIMS: begin
          if (prod_lt) begin
            pw_q[k_q + PIDX_W'(1)] <= prod[RANK_W-1:0];
            k_q <= k_q + PIDX_W'(1);
          end
        end
        OP_DIG_INIT: begin
          tz_q  <= k_q;
          pos_q <= '0;
          rem_q <= rank_q;
          j_q   <= jtop_q;
          dig_q <= '0;
        end
        OP_DIG_STEP: begin
          if (ge) begin
            rem_q <= rem_q - shifted[RANK_W-1:0];
            dig_q <= dig_q | (DIG_W'(1) << j_q);
          end
          j_q <= j_q - BIT_W'(1);
        end
        OP_DIG_END: begin
          // lowest nonzero digit sets depth and position
          if (dig_q != '0) begin
            tz_q  <= k_q;
            pos_q <= dig_q;
          end
          j_q   <= jtop_q;
          dig_q <= '0;
          if (k_q != '0) k_q <= k_q - PIDX_W'(1);
        end
        OP_SUCC:  k_q <= tz_q - PIDX_W'(1);
        OP_CHILD: k_q <= k_q - PIDX_W'(1);
        default: ;
      endcase
    end
  end

  assign stat_o.in_vld   = req_i.valid;
  assign stat_o.rank_bad = ({1'b0, rank_q} >= size_q);
  assign stat_o.prod_lt  = prod_lt;
  assign stat_o.j_nz     = (j_q != '0);
  assign stat_o.k_nz     = (k_q != '0);
  assign stat_o.tz_z     = (tz_q == '0);
  assign stat_o.out_busy = out_v_q && !rsp_o.ready;

endmodule

`default_nettype wire

/* design/cube_tree_peer_finder_core.sv */
// time from accept to the last beat grows with the cube dimensions, the bits per radix digit
//   and the lower dimensions searched for children, and with every stall of the sink
// throughput: one request at a time, next request taken the cycle after its last beat
//   is staged; the digit loop of the shared compare-subtract unit sets the figure
// reset: cube_radix returns to 2, sequencer to idle, output and pending beats dropped
`default_nettype none

module cube_tree_peer_finder_core
  import ctpf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cube_radix_we_i,
  input  wire logic [RADIX_W-1:0] cube_radix_i,
  ctpf_req_if.sink                req_i,
  ctpf_rsp_if.source              rsp_o
);

  // configuration register; the user must write it only while the block is idle, the block does not enforce this
  logic [RADIX_W-1:0] cube_radix_q, cube_radix_d;

  // control word from the microprogram and status flags back to it
  ctpf_ctrl_t ctrl;
  ctpf_stat_t stat;

  always_comb begin
    cube_radix_d = cube_radix_we_i ? cube_radix_i : cube_radix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_radix_q <= RADIX_RESET;
    end else begin
      cube_radix_q <= cube_radix_d;
    end
  end

  // the microprogram walks: load, rank check (invalid beat if outside the group),
  // dimension count by repeated multiply, top-down digit extraction of the rank,
  // then parent, successor and children peers; one peer beat is held back to place the last mark
  ctpf_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // datapath holds the radix power table and the output register, so a
  // finished beat can wait for the sink while the walk goes on up to its next peer step
  ctpf_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .radix_i (cube_radix_q),
    .stat_o  (stat),
    .req_i   (req_i),
    .rsp_o   (rsp_o)
  );

`ifndef ASSERT_OFF
  // a request is worked on alone
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while another was in progress");

  // back to idle only once the final beat of the item is staged
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(req_i.ready) |-> rsp_o.valid && rsp_o.last)
    else $error("sequencer idle without a staged last beat");

  // no-peer and invalid beats stand alone and carry rank zero
  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.peer_kind == KIND_NONE || rsp_o.peer_kind == KIND_INVALID)
    |-> rsp_o.last && rsp_o.peer_rank == '0)
    else $error("status beat without last mark or with nonzero rank");
`endif

endmodule

`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the cube tree peer finder core
`default_nettype none

module testbench
  import ctpf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // one response beat as the checker sees it
  typedef struct packed {
    logic [1:0]        kind;
    logic [RANK_W-1:0] rank;
    logic              last;
  } peer_beat_t;

  // holds the peer lists still owed by the block and checks beats against them
  class peer_list_board;
    peer_beat_t expected_peers_q[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int pending_count();
      return expected_peers_q.size();
    endfunction

    function peer_beat_t make_beat(logic [1:0] kind, int unsigned rank);
      peer_beat_t b;
      b.kind = kind;
      b.rank = rank[RANK_W-1:0];
      b.last = 1'b0;
      return b;
    endfunction

    // works out the peer list of one request and queues it
    function void note_request(logic mode, logic [SIZE_W-1:0] size_in,
                               logic [RANK_W-1:0] rank_in, logic [RADIX_W-1:0] radix_in);
      int unsigned rdx, sz, rk, dims, depth, stride, pos, t, d;
      logic [1:0]  up_kind, down_kind;
      peer_beat_t  found[$];
      peer_beat_t  b;
      rdx = 32'(radix_in);
      sz  = 32'(size_in);
      rk  = 32'(rank_in);
      // clamp radix and group to the supported range
      if (rdx < 2) rdx = 2;
      if (rdx > 256) rdx = 256;
      if (sz > 65536) sz = 65536;
      up_kind   = mode ? KIND_SEND : KIND_RECV;
      down_kind = mode ? KIND_RECV : KIND_SEND;
      if (rk >= sz) begin
        b = make_beat(KIND_INVALID, 0);
        b.last = 1'b1;
        expected_peers_q = {expected_peers_q, b};
        return;
      end
      // digits of size-1 in base radix, at least one
      dims = 1;
      t = (sz - 1) / rdx;
      while (t > 0) begin
        dims++;
        t = t / rdx;
      end
      stride = 1;
      for (d = 1; d < dims; d++) stride = stride * rdx;
      // climb down while the rank is not aligned to the stride
      depth = 0;
      while (stride > 1 && (rk % stride) != 0) begin
        depth++;
        stride = stride / rdx;
      end
      pos = (rk % (stride * rdx)) / stride;
      if (rk != 0) found = {found, make_beat(up_kind, rk - stride)};
      if (pos < rdx - 1 && rk + stride < sz) found = {found, make_beat(down_kind, rk + stride)};
      for (d = depth + 1; d < dims; d++) begin
        stride = stride / rdx;
        if (rk + stride < sz) found = {found, make_beat(down_kind, rk + stride)};
      end
      if (found.size() == 0) found = {found, make_beat(KIND_NONE, 0)};
      for (d = 0; d < found.size(); d++) begin
        b = found[d];
        b.last = (d == found.size() - 1);
        expected_peers_q = {expected_peers_q, b};
      end
    endfunction

    function void check_beat(logic [1:0] kind, logic [RANK_W-1:0] rank, logic last);
      peer_beat_t want;
      if (expected_peers_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("error: unexpected peer beat kind %0d rank %0d last %0d", kind, rank, last);
        return;
      end
      want = expected_peers_q.pop_front();
      if (kind !== want.kind || rank !== want.rank || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("error: peer beat expected kind %0d rank %0d last %0d, got %0d %0d %0d",
                   want.kind, want.rank, want.last, kind, rank, last);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               radix_we;
  logic [RADIX_W-1:0] radix_val;
  // register value as last written, used by the predictor
  logic [RADIX_W-1:0] radix_setting;
  // when set neither side idles
  bit                 steady;

  ctpf_req_if req ();
  ctpf_rsp_if rsp ();

  peer_list_board board;

  cube_tree_peer_finder_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cube_radix_we_i (radix_we),
    .cube_radix_i    (radix_val),
    .req_i           (req.sink),
    .rsp_o           (rsp.source)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // response side stalls about a third of the time unless in a steady stretch
  always @(posedge clk) begin
    rsp.ready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // everything is stable at the falling edge, so a beat seen here is taken
  // at the next rising edge; requests are noted before beats are checked
  always @(negedge clk) begin
    if (rst_n) begin
      if (req.valid && req.ready)
        board.note_request(req.pattern_mode, req.group_size, req.local_rank, radix_setting);
      if (rsp.valid && rsp.ready)
        board.check_beat(rsp.peer_kind, rsp.peer_rank, rsp.last);
    end
  end

  // called just after a rising edge; returns just after the accepting edge
  task automatic send_request(logic mode, logic [SIZE_W-1:0] size, logic [RANK_W-1:0] rank);
    while (!steady && $urandom_range(0, 99) < 33) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.pattern_mode <= mode;
    req.group_size   <= size;
    req.local_rank   <= rank;
    do @(negedge clk); while (!req.ready);
    @(posedge clk);
  endtask

  // register writes only once every owed beat has come out
  task automatic write_radix(logic [RADIX_W-1:0] value);
    req.valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    radix_we  <= 1'b1;
    radix_val <= value;
    @(posedge clk);
    radix_we      <= 1'b0;
    radix_setting = value;
  endtask

  // random requests, mostly ranks inside the group
  task automatic random_requests(int count);
    int               i;
    int unsigned      sel;
    logic             mode;
    logic [SIZE_W-1:0] size;
    logic [RANK_W-1:0] rank;
    for (i = 0; i < count; i++) begin
      sel  = $urandom_range(0, 99);
      mode = 1'($urandom_range(0, 1));
      if (sel < 10) begin
        // rank outside the group
        size = SIZE_W'($urandom_range(0, 65535));
        rank = RANK_W'($urandom_range(size, 65535));
      end else if (sel < 40) begin
        // small groups
        size = SIZE_W'($urandom_range(1, 64));
        rank = RANK_W'($urandom_range(0, size - 1));
      end else if (sel < 70) begin
        size = SIZE_W'($urandom_range(1, 65536));
        rank = RANK_W'($urandom_range(0, size - 1));
      end else if (sel < 80) begin
        // oversized group, clamped by the block
        size = SIZE_W'($urandom_range(65537, 131071));
        rank = RANK_W'($urandom_range(0, 65535));
      end else begin
        // aligned ranks sit high in the tree and have many children
        size = SIZE_W'($urandom_range(1, 131071));
        rank = RANK_W'($urandom_range(0, 65535) & (32'hffff << $urandom_range(0, 15)));
        if (size <= 65536 && rank >= size) rank = RANK_W'(rank % size);
      end
      send_request(mode, size, rank);
    end
  endtask

  initial begin
    int guard;
    board            = new();
    steady           = 1'b0;
    rst_n            = 1'b0;
    radix_we         = 1'b0;
    radix_val        = '0;
    radix_setting    = RADIX_RESET;
    req.valid        = 1'b0;
    req.pattern_mode = 1'b0;
    req.group_size   = '0;
    req.local_rank   = '0;
    rsp.ready        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset radix
    send_request(1'b0, 17'd1, 16'd0);          // lone node, broadcast
    send_request(1'b1, 17'd1, 16'd0);          // lone node, reduce
    send_request(1'b0, 17'd0, 16'd0);          // empty group
    send_request(1'b1, 17'd0, 16'd65535);
    send_request(1'b0, 17'd5, 16'd5);          // rank just past the group
    send_request(1'b1, 17'd5, 16'd65535);
    send_request(1'b0, 17'd65536, 16'd0);      // full group, root
    send_request(1'b1, 17'd65536, 16'd65535);
    send_request(1'b0, 17'd131071, 16'd65535); // oversized group
    send_request(1'b1, 17'd65537, 16'd32768);
    send_request(1'b0, 17'd131071, 16'd0);
    send_request(1'b0, 17'd2, 16'd1);
    send_request(1'b1, 17'd2, 16'd1);
    send_request(1'b0, 17'd7, 16'd3);
    send_request(1'b1, 17'd100, 16'd37);
    send_request(1'b0, 17'd65536, 16'd21845);
    send_request(1'b1, 17'd65535, 16'd43690);
    send_request(1'b0, 17'd16, 16'd15);
    send_request(1'b1, 17'd65536, 16'd32768);
    send_request(1'b0, 17'd3, 16'd0);

    // random part over several radix settings, clamped ones included
    write_radix(9'd256);
    send_request(1'b0, 17'd65536, 16'd0);
    send_request(1'b1, 17'd65536, 16'd257);
    random_requests(50);
    write_radix(9'd3);
    random_requests(50);
    write_radix(9'd0);
    steady = 1'b1;
    random_requests(52);
    steady = 1'b0;
    write_radix(9'd511);
    random_requests(50);
    write_radix(9'd1);
    random_requests(50);
    write_radix(9'd257);
    random_requests(50);
    write_radix(9'd7);
    random_requests(50);
    write_radix(RADIX_W'($urandom_range(2, 256)));
    random_requests(50);

    // drain, then allow a few more beats to show up if any are stray
    req.valid <= 1'b0;
    for (guard = 0; guard < 50000 && board.pending_count() != 0; guard++) @(posedge clk);
    repeat (250) @(posedge clk);
    if (board.pending_count() != 0)
      $display("error: %0d peer beats never arrived", board.pending_count());
    if (board.errors == 0 && board.pending_count() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far above the slowest correct run
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
